// ===== rtl/core/vbap5_pkg.sv =====
// ----------------------------------------------------------------------------
// vbap5_pkg
// Layout constants, pair table and small arithmetic helpers for the panner.
// ----------------------------------------------------------------------------
package vbap5_pkg;

  localparam int NumSpk   = 5;
  localparam int NumPairs = 5;
  localparam int SmpW     = 24;
  localparam int SpkIdxW  = 3;

  localparam logic [15:0] RampStepReset = 16'd1024;
  localparam logic [30:0] Unity         = 31'h4000_0000;

  typedef logic [SpkIdxW-1:0] spk_idx_t;
  typedef logic signed [1:0]  coef_t;

  // Adjacent pairs by azimuth: Rs-R, R-C, C-L, L-Ls, Ls-Rs
  localparam spk_idx_t PairC1 [NumPairs] = '{3'd4, 3'd1, 3'd2, 3'd0, 3'd3};
  localparam spk_idx_t PairC2 [NumPairs] = '{3'd1, 3'd2, 3'd0, 3'd3, 3'd4};
  localparam coef_t    PairAx [NumPairs] = '{-2'sd1,  2'sd0,  2'sd1,  2'sd1, -2'sd1};
  localparam coef_t    PairAy [NumPairs] = '{-2'sd1, -2'sd1, -2'sd1,  2'sd1,  2'sd1};
  localparam coef_t    PairBx [NumPairs] = '{ 2'sd1,  2'sd1,  2'sd0, -2'sd1, -2'sd1};
  localparam coef_t    PairBy [NumPairs] = '{-2'sd1,  2'sd1,  2'sd1,  2'sd1, -2'sd1};

  // Scale a direction component by a coefficient of -1, 0 or +1
  function automatic logic signed [17:0] coef_mul(coef_t c, logic signed [15:0] v);
    logic signed [17:0] ext;
    ext = {{2{v[15]}}, v};
    case (c)
      2'sd1:   coef_mul = ext;
      -2'sd1:  coef_mul = -ext;
      default: coef_mul = 18'sd0;
    endcase
  endfunction

  // Saturate a 34-bit value to 32 bits
  function automatic logic signed [31:0] sat32(logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF)       sat32 = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) sat32 = 32'sh8000_0000;
    else                            sat32 = v[31:0];
  endfunction

  // Saturate a 26-bit value to the sample width
  function automatic logic signed [SmpW-1:0] sat_smp(logic signed [25:0] v);
    if (v > 26'sh07F_FFFF)       sat_smp = 24'sh7F_FFFF;
    else if (v < -26'sh080_0000) sat_smp = 24'sh80_0000;
    else                         sat_smp = v[SmpW-1:0];
  endfunction

endpackage

// ===== rtl/core/vbap_5ch_panner_with_gain_ramp.sv =====
// ----------------------------------------------------------------------------
// vbap_5ch_panner_with_gain_ramp
// 2D amplitude panner onto L, R, C, Ls, Rs with linear gain ramps and LFE.
//
//   channel | signals                  | payload
//   s_axis  | s_tvalid/s_tready        | tuser mode, tdata dir_x,dir_y,sample
//   m_axis  | m_tvalid/m_tready        | tdata six 24-bit speaker samples
//   cfg     | cfg_wr_en                | cfg_wr_data ramp_step
//
// A sample item runs three steps per speaker through one shared
// multiplier (weight update, product, scale) between accept and hand-off.
// A direction item runs accept, one check per pair and five increments,
// plus, per matching pair, a 32-bit square root and two 32-bit divisions,
// one bit per cycle (a zero direction skips the divisions). Reset (rst,
// synchronous) clears weights, increments and sets ramp_step to 1024. Input
// is taken only in idle; a held result stalls only hand-off.
// ----------------------------------------------------------------------------
module vbap_5ch_panner_with_gain_ramp (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,   // dir_x[15:0], dir_y[31:16], sample[55:32]
  input  logic         s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // out_left, out_right, out_center, out_lfe,
                                  // out_left_surround, out_right_surround
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);
  import vbap5_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PAIR, S_SQRT, S_DIV, S_INC, S_SW, S_SMUL, S_SOUT, S_DONE
  } state_t;

  state_t state;
  logic [15:0] ramp_step;
  logic signed [15:0] dir_x, dir_y;
  logic signed [SmpW-1:0] smp;
  logic [2:0] pk;
  spk_idx_t sk;
  logic [4:0] cnt;
  logic div_sel;
  logic [16:0] pa, pb;
  logic [63:0] sq_v, sq_res, sq_bit;
  logic [31:0] root;
  logic [31:0] div_rem, div_q;
  logic [30:0] gain_a;
  logic [30:0] target [NumSpk];
  logic signed [31:0] weight [NumSpk];
  logic signed [31:0] incr [NumSpk];
  logic signed [31:0] wreg;
  logic signed [55:0] prod;
  logic signed [SmpW-1:0] res_st [NumSpk];

  // Combinational helpers for the current step
  logic signed [17:0] a_raw, b_raw;
  logic [33:0] sq_sum;
  logic [63:0] sq_try;
  logic [32:0] div_t;
  logic [31:0] div_qn;
  logic [30:0] gain_cl;
  logic signed [32:0] d_diff;
  logic signed [49:0] d_prod;
  logic signed [33:0] inc_sh, w_sum;
  logic signed [25:0] o_sh;

  always_comb begin
    a_raw   = coef_mul(PairAx[pk], dir_x) + coef_mul(PairAy[pk], dir_y);
    b_raw   = coef_mul(PairBx[pk], dir_x) + coef_mul(PairBy[pk], dir_y);
    sq_sum  = 34'(a_raw[16:0]) * 34'(a_raw[16:0]) + 34'(b_raw[16:0]) * 34'(b_raw[16:0]);
    sq_try  = sq_res + sq_bit;
    div_t   = {div_rem, 1'b0};
    div_qn  = {div_q[30:0], (div_t >= {1'b0, root})};
    gain_cl = (div_qn > 32'(Unity)) ? Unity : div_qn[30:0];
    d_diff  = $signed({2'b00, target[sk]}) - 33'(weight[sk]);
    d_prod  = d_diff * $signed({1'b0, ramp_step});
    inc_sh  = 34'(d_prod >>> 16);
    w_sum   = 34'(weight[sk]) + 34'(incr[sk]);
    o_sh    = 26'(prod >>> 30);
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ramp_step <= RampStepReset;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < NumSpk; i++) begin
        weight[i] <= '0;
        incr[i]   <= '0;
      end
    end else begin
      if (cfg_wr_en) ramp_step <= cfg_wr_data;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        // Take an item and pick the path by mode
        S_IDLE: begin
          if (s_tvalid) begin
            dir_x <= s_tdata[15:0];
            dir_y <= s_tdata[31:16];
            smp   <= s_tdata[55:32];
            pk    <= '0;
            sk    <= '0;
            if (s_tuser) begin
              state <= S_SW;
            end else begin
              for (int i = 0; i < NumSpk; i++) target[i] <= '0;
              state <= S_PAIR;
            end
          end
        end
        // Check one pair; on a match, load the square root
        S_PAIR: begin
          if (a_raw < 0 || b_raw < 0) begin
            if (pk == 3'(NumPairs - 1)) state <= S_INC;
            pk <= pk + 3'd1;
          end else begin
            pa     <= a_raw[16:0];
            pb     <= b_raw[16:0];
            sq_v   <= {2'b00, sq_sum, 28'd0};
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            cnt    <= '0;
            state  <= S_SQRT;
          end
        end
        // One root bit per cycle
        S_SQRT: begin
          if (sq_v >= sq_try) begin
            sq_v   <= sq_v - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            div_sel <= 1'b0;
            state   <= S_DIV;
            root    <= (sq_v >= sq_try) ? 32'((sq_res >> 1) + sq_bit) : 32'(sq_res >> 1);
            div_rem <= {3'd0, pa, 12'd0};
            div_q   <= '0;
          end
        end
        // One quotient bit per cycle, first gain a then gain b
        S_DIV: begin
          if (root == '0) begin
            // Zero direction: both gains are zero
            target[PairC1[pk]] <= '0;
            target[PairC2[pk]] <= '0;
            if (pk == 3'(NumPairs - 1)) state <= S_INC;
            else state <= S_PAIR;
            pk <= pk + 3'd1;
          end else if (cnt != 5'd31) begin
            div_rem <= div_qn[0] ? 32'(div_t - {1'b0, root}) : div_t[31:0];
            div_q   <= div_qn;
            cnt     <= cnt + 5'd1;
          end else begin
            // Last bit: take the full quotient from div_qn
            cnt <= '0;
            if (!div_sel) begin
              gain_a  <= gain_cl;
              div_sel <= 1'b1;
              div_rem <= {3'd0, pb, 12'd0};
              div_q   <= '0;
            end else begin
              target[PairC1[pk]] <= gain_a;
              target[PairC2[pk]] <= gain_cl;
              if (pk == 3'(NumPairs - 1)) state <= S_INC;
              else state <= S_PAIR;
              pk <= pk + 3'd1;
            end
          end
        end
        // Set one ramp increment per cycle
        S_INC: begin
          incr[sk] <= sat32(inc_sh);
          sk <= sk + 3'd1;
          if (sk == spk_idx_t'(NumSpk - 1)) state <= S_IDLE;
        end
        // Advance one weight
        S_SW: begin
          weight[sk] <= sat32(w_sum);
          wreg       <= sat32(w_sum);
          state      <= S_SMUL;
        end
        S_SMUL: begin
          prod  <= wreg * smp;
          state <= S_SOUT;
        end
        S_SOUT: begin
          res_st[sk] <= sat_smp(o_sh);
          sk <= sk + 3'd1;
          state <= (sk == spk_idx_t'(NumSpk - 1)) ? S_DONE : S_SW;
        end
        // Hand the item to the output register once it is free
        S_DONE: begin
          if (!m_tvalid) begin
            m_tdata  <= {res_st[4], res_st[3], smp, res_st[2], res_st[1], res_st[0]};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
